[rtl/core/kmr_pkg.sv]
// ----------------------------------------------------------------------------
// kmr_pkg
// Shared opcodes, status codes, modes, sizes and the command record.
// ----------------------------------------------------------------------------
package kmr_pkg;

   localparam int OP_W     = 3;
   localparam int STATUS_W = 4;
   localparam int MODE_W   = 3;
   localparam int ENTRY_W  = 49;

   // store sizes, fixed by the 7-bit length and 4-bit filled fields
   localparam int SLOTS           = 8;
   localparam int EVENTS_PER_SLOT = 64;

   localparam logic [OP_W-1:0] OP_KEY     = 3'd0;
   localparam logic [OP_W-1:0] OP_RECORD  = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
   localparam logic [OP_W-1:0] OP_STATUS  = 3'd4;
   localparam logic [OP_W-1:0] OP_SLOT    = 3'd5;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd6;
   localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

   localparam logic [STATUS_W-1:0] ST_IGNORED   = 4'd0;
   localparam logic [STATUS_W-1:0] ST_RECORDED  = 4'd1;
   localparam logic [STATUS_W-1:0] ST_REC_START = 4'd2;
   localparam logic [STATUS_W-1:0] ST_AWAIT     = 4'd3;
   localparam logic [STATUS_W-1:0] ST_DEL_ARMED = 4'd4;
   localparam logic [STATUS_W-1:0] ST_SAVED     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_FULL      = 4'd6;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 4'd7;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd8;
   localparam logic [STATUS_W-1:0] ST_PLAY_ST   = 4'd9;
   localparam logic [STATUS_W-1:0] ST_PLAYED    = 4'd10;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 4'd11;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 4'd12;
   localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 4'd13;
   localparam logic [STATUS_W-1:0] ST_STATUS    = 4'd14;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 4'd15;

   localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REC    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ASSIGN = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PLAY   = 3'd4;

   // one decoded command from the front end
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [ENTRY_W-1:0] entry;
      logic [7:0]         slot_index;
   } cmd_type;

endpackage

[rtl/core/kmr_front.sv]
// ----------------------------------------------------------------------------
// kmr_front
// Input stage and command queue: unpacks items and buffers them for the engine.
// ----------------------------------------------------------------------------
module kmr_front #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,
   input  logic [2:0]        req_tuser,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output kmr_pkg::cmd_type  cmd
);
   import kmr_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type            q_ff [DEPTH];
   logic [AW-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]        cnt_ff, cnt_in;
   cmd_type            item;
   logic               push, pop;

   assign item.op         = req_tuser;
   assign item.entry      = req_tdata[48:0];
   assign item.slot_index = req_tdata[56:49];

   assign req_tready = (cnt_ff != (AW+1)'(DEPTH));
   assign cmd_valid  = (cnt_ff != '0);
   assign cmd        = q_ff[rp_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH))
      else $error("queue count over depth");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count missed a push");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wp_ff == rp_ff))
      else $error("empty queue with split pointers");

endmodule

[rtl/core/kmr_engine.sv]
// ----------------------------------------------------------------------------
// kmr_engine
// Back end: mode machine, recording buffer, slot store and result register.
// ----------------------------------------------------------------------------
module kmr_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  kmr_pkg::cmd_type  cmd,
   input  logic [15:0]       timeout_ticks,
   output logic              busy,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,
   output logic [3:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import kmr_pkg::*;

   localparam int EA = (EVENTS_PER_SLOT > 1) ? $clog2(EVENTS_PER_SLOT) : 1;
   localparam int SA = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LW = 7;
   localparam int FW = 4;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_COPY  = 6'b000100,
      S_PLAYR = 6'b001000,
      S_PLAYW = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type           st_ff, st_in;
   cmd_type             c_ff;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [LW-1:0]       len_ff [SLOTS];
   logic [LW-1:0]       rlen_ff, rlen_in;
   logic [SA-1:0]       pslot_ff, pslot_in;
   logic [LW-1:0]       ppos_ff, ppos_in;
   logic [15:0]         tmo_ff, tmo_in;
   logic [ENTRY_W-1:0]  rbuf [EVENTS_PER_SLOT];
   logic [ENTRY_W-1:0]  sstore [SLOTS*EVENTS_PER_SLOT];
   logic [ENTRY_W-1:0]  rbuf_rd_ff, sstore_rd_ff;
   logic [LW-1:0]       ci_ff, ci_in;
   logic [SA-1:0]       cslot_ff;
   logic                len_we, len_clr;
   logic [FW-1:0]       filled_ff, filled_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic [7:0]          snum_ff, snum_in;
   logic [ENTRY_W-1:0]  pl_ff, pl_in;
   logic                last_ff, last_in;
   logic                copy_rd_ff;
   logic [SA-1:0]       sidx;
   logic                sok;
   logic [LW-1:0]       slen;
   logic [LW-1:0]       ci_prev;
   logic [SA+EA-1:0]    ss_wr_addr, ss_rd_addr;

   assign sidx = SA'(c_ff.slot_index);
   assign sok  = ({24'd0, c_ff.slot_index} < 32'(SLOTS));
   assign slen = len_ff[sidx];

   assign cmd_ready  = (st_ff == S_IDLE);
   assign busy       = (st_ff != S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = stat_ff;
   // page, code, imods, emods, press, slot, mode, filled, recorded
   assign rsp_tdata  = {1'b0, rlen_ff, filled_ff, mode_ff, snum_ff, pl_ff};

   always_comb begin
      st_in     = st_ff;
      mode_in   = mode_ff;
      rlen_in   = rlen_ff;
      pslot_in  = pslot_ff;
      ppos_in   = ppos_ff;
      tmo_in    = tmo_ff;
      ci_in     = ci_ff;
      stat_in   = stat_ff;
      snum_in   = snum_ff;
      pl_in     = pl_ff;
      last_in   = last_ff;
      filled_in = filled_ff;
      len_we    = 1'b0;
      len_clr   = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               st_in = S_EXEC;
            end
         end
         S_EXEC: begin
            st_in   = S_OUT;
            stat_in = ST_IGNORED;
            snum_in = '0;
            pl_in   = '0;
            last_in = 1'b0;
            case (c_ff.op)
               OP_KEY: begin
                  if (mode_ff == MODE_REC) begin
                     if ({25'd0, rlen_ff} >= 32'(EVENTS_PER_SLOT)) begin
                        mode_in = MODE_ASSIGN;
                        tmo_in  = timeout_ticks;
                        stat_in = ST_OVERFLOW;
                     end else begin
                        rlen_in = rlen_ff + 1'b1;
                        stat_in = ST_RECORDED;
                     end
                  end
               end
               OP_RECORD: begin
                  if (mode_ff != MODE_PLAY) begin
                     rlen_in = '0;
                     tmo_in  = '0;
                     mode_in = MODE_REC;
                     stat_in = ST_REC_START;
                  end
               end
               OP_STOP: begin
                  if (mode_ff == MODE_REC) begin
                     mode_in = MODE_ASSIGN;
                     tmo_in  = timeout_ticks;
                     stat_in = ST_AWAIT;
                  end
               end
               OP_DELETE: begin
                  if (mode_ff == MODE_IDLE) begin
                     mode_in = MODE_DELETE;
                     tmo_in  = timeout_ticks;
                     stat_in = ST_DEL_ARMED;
                  end
               end
               OP_STATUS: begin
                  if (mode_ff == MODE_IDLE) begin
                     stat_in = ST_STATUS;
                  end
               end
               OP_SLOT: begin
                  snum_in = c_ff.slot_index;
                  if (!sok) begin
                     stat_in = ST_BAD_SLOT;
                  end else if (mode_ff == MODE_ASSIGN) begin
                     if (slen != '0) begin
                        tmo_in  = timeout_ticks;
                        stat_in = ST_FULL;
                     end else begin
                        tmo_in  = '0;
                        mode_in = MODE_IDLE;
                        stat_in = ST_SAVED;
                        len_we  = 1'b1;
                        if (rlen_ff != '0) begin
                           filled_in = filled_ff + 1'b1;
                           ci_in     = '0;
                           st_in     = S_COPY;
                        end
                     end
                  end else if (mode_ff == MODE_DELETE) begin
                     tmo_in  = '0;
                     mode_in = MODE_IDLE;
                     if (slen == '0) begin
                        stat_in = ST_EMPTY;
                     end else begin
                        len_clr   = 1'b1;
                        filled_in = filled_ff - 1'b1;
                        stat_in   = ST_DELETED;
                     end
                  end else if (mode_ff == MODE_IDLE) begin
                     if (slen == '0) begin
                        stat_in = ST_EMPTY;
                     end else begin
                        mode_in  = MODE_PLAY;
                        pslot_in = sidx;
                        ppos_in  = '0;
                        stat_in  = ST_PLAY_ST;
                     end
                  end
               end
               OP_TICK: begin
                  if (mode_ff == MODE_PLAY) begin
                     if (ppos_ff >= len_ff[pslot_ff]) begin
                        mode_in = MODE_IDLE;
                     end else begin
                        st_in = S_PLAYR;
                     end
                  end else if (mode_ff == MODE_ASSIGN || mode_ff == MODE_DELETE) begin
                     if (tmo_ff <= 16'd1) begin
                        tmo_in  = '0;
                        mode_in = MODE_IDLE;
                        stat_in = ST_TIMEOUT;
                     end else begin
                        tmo_in = tmo_ff - 1'b1;
                     end
                  end
               end
               default: begin
                  stat_in = ST_UNKNOWN;
               end
            endcase
         end
         S_COPY: begin
            // one entry a cycle: read ahead, write behind
            ci_in = ci_ff + 1'b1;
            if (ci_ff == rlen_ff) begin
               st_in = S_OUT;
            end
         end
         S_PLAYR: begin
            st_in = S_PLAYW;
         end
         S_PLAYW: begin
            pl_in   = sstore_rd_ff;
            ppos_in = ppos_ff + 1'b1;
            snum_in = 8'(pslot_ff);
            stat_in = ST_PLAYED;
            if ((ppos_ff + 1'b1) >= len_ff[pslot_ff]) begin
               last_in = 1'b1;
               mode_in = MODE_IDLE;
            end
            st_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         mode_ff   <= MODE_IDLE;
         rlen_ff   <= '0;
         pslot_ff  <= '0;
         ppos_ff   <= '0;
         tmo_ff    <= '0;
         filled_ff <= '0;
         last_ff   <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         st_ff     <= st_in;
         mode_ff   <= mode_in;
         rlen_ff   <= rlen_in;
         pslot_ff  <= pslot_in;
         ppos_ff   <= ppos_in;
         tmo_ff    <= tmo_in;
         filled_ff <= filled_in;
         last_ff   <= last_in;
         if (len_we) begin
            len_ff[sidx] <= rlen_ff;
         end else if (len_clr) begin
            len_ff[sidx] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ci_ff      <= ci_in;
      stat_ff    <= stat_in;
      snum_ff    <= snum_in;
      pl_ff      <= pl_in;
      copy_rd_ff <= (st_ff == S_COPY) && (ci_ff != rlen_ff);
      if (st_ff == S_IDLE && cmd_valid) begin
         c_ff <= cmd;
      end
      if (st_ff == S_EXEC) begin
         cslot_ff <= sidx;
      end
   end

   // recording buffer
   always_ff @(posedge clock) begin
      if (st_ff == S_EXEC && c_ff.op == OP_KEY && mode_ff == MODE_REC
          && {25'd0, rlen_ff} < 32'(EVENTS_PER_SLOT)) begin
         rbuf[rlen_ff[EA-1:0]] <= c_ff.entry;
      end
      rbuf_rd_ff <= rbuf[ci_ff[EA-1:0]];
   end

   // slot store, one row of EVENTS_PER_SLOT entries per slot
   assign ci_prev    = ci_ff - 1'b1;
   assign ss_wr_addr = {cslot_ff, ci_prev[EA-1:0]};
   assign ss_rd_addr = {pslot_ff, ppos_ff[EA-1:0]};
   always_ff @(posedge clock) begin
      if (copy_rd_ff) begin
         sstore[ss_wr_addr] <= rbuf_rd_ff;
      end
      sstore_rd_ff <= sstore[ss_rd_addr];
   end

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_OUT && !rsp_tready) |=> st_ff == S_OUT && $stable(stat_ff))
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tlast |-> (stat_ff == ST_PLAYED || st_ff != S_OUT))
      else $error("last flag on a non-played result");
   assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FW'(SLOTS))
      else $error("filled count over slot count");

endmodule

[rtl/core/keystroke_macro_recorder.sv]
// ----------------------------------------------------------------------------
// keystroke_macro_recorder
// Records key events and saves, deletes and replays them from macro slots.
// ----------------------------------------------------------------------------
// Items pass a two-entry queue into an engine that runs one item at a time:
// most items go from queue through the execute state to the result, a replayed
// event also passes the slot store read states, and a save copies the events
// from the recording buffer into the slot store (one memory port each) before
// the result; saving an empty recording skips the copy. A stalled result holds
// the engine, and the queue then takes up to two more items.
// Every item gives exactly one result; rsp_tlast marks the final replayed event.
module keystroke_macro_recorder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // page, code, implicit mods, explicit mods, press, slot index
   input  logic [63:0] req_tdata,
   // opcode
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out page, out code, out implicit mods, out explicit mods, out press,
   // slot number, mode now, filled slots, recorded events
   output logic [71:0] rsp_tdata,
   // status code
   output logic [3:0]  rsp_tuser,
   // last_of_macro
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import kmr_pkg::*;

   cmd_type     cmd;
   logic        cmd_valid, cmd_ready, busy;
   logic [15:0] tmo_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff <= 16'd100;
      end else if (csr_valid) begin
         tmo_ff <= csr_data;
      end
   end

   kmr_front #(.DEPTH(2)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .cmd_valid, .cmd_ready, .cmd
   );

   kmr_engine u_engine (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .timeout_ticks(tmo_ff), .busy,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> busy)
      else $error("result shown while engine idle");

endmodule
